// ===== rtl/wpm_pkg.sv =====
// wpm_pkg: shared types, constants and the star closure function
// for the wildcard pattern matcher; no dependencies
`default_nettype none

package wpm_pkg;

    // pattern store size and derived widths
    localparam int MAX_PATTERN = 32;
    localparam int PREFIX_W    = MAX_PATTERN + 1;
    localparam int CNT_W       = $clog2(MAX_PATTERN + 1);
    localparam int IDX_W       = $clog2(MAX_PATTERN);
    localparam int PREFIX_LVLS = $clog2(PREFIX_W);

    localparam int KIND_W = 2;
    localparam int SYM_W  = 8;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_PATTERN = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TEXT    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_END     = 2'd2;

    // wildcard symbols
    localparam logic [SYM_W-1:0] SYM_STAR = 8'h2A;
    localparam logic [SYM_W-1:0] SYM_ANY  = 8'h3F;

    typedef logic [PREFIX_W-1:0]    prefix_t;
    typedef logic [MAX_PATTERN-1:0] star_t;
    typedef logic [CNT_W-1:0]       count_t;
    typedef logic [SYM_W-1:0]       sym_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        sym_t              symbol;
    } item_t;

    // step command from the input stage to the matcher
    typedef struct packed {
        logic  valid;
        item_t item;
    } step_t;

    // end-of-text verdict
    typedef struct packed {
        logic matched;
        logic error;
    } result_t;

    // star closure as a log-depth prefix: bit j+1 picks up bit j across a star
    function automatic prefix_t star_close(prefix_t v, star_t s);
        prefix_t g;
        prefix_t p;
        prefix_t ng;
        prefix_t np;
        g = v;
        p = {s, 1'b0};
        for (int l = 0; l < PREFIX_LVLS; l++)
        begin
            ng = g;
            np = p;
            for (int j = 0; j < PREFIX_W; j++)
            begin
                if (j >= (1 << l))
                begin
                    ng[j] = g[j] | (p[j] & g[j - (1 << l)]);
                    np[j] = p[j] & p[j - (1 << l)];
                end
            end
            g = ng;
            p = np;
        end
        return g;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/wpm_item_if.sv =====
// wpm_item_if: valid/ready channel carrying one input item (kind, symbol)
// depends on wpm_pkg for field widths
`default_nettype none

interface wpm_item_if;
    logic                        valid;
    logic                        ready;
    logic [wpm_pkg::KIND_W-1:0]  kind;
    logic [wpm_pkg::SYM_W-1:0]   symbol;

    modport source (output valid, output kind, output symbol, input ready);
    modport sink   (input valid, input kind, input symbol, output ready);
endinterface

`default_nettype wire

// ===== rtl/wpm_result_if.sv =====
// wpm_result_if: valid/ready channel carrying one result item (matched, error)
// no dependencies
`default_nettype none

interface wpm_result_if;
    logic valid;
    logic ready;
    logic matched;
    logic error;

    modport source (output valid, output matched, output error, input ready);
    modport sink   (input valid, input matched, input error, output ready);
endinterface

`default_nettype wire

// ===== rtl/wildcard_pattern_matcher_core.sv =====
// wildcard_pattern_matcher_core: top level, input register, result register
// depends on wpm_pkg, wpm_item_if, wpm_result_if and wpm_nfa
//
// Usage: items arrive on the item channel (valid/ready). Kind 0 loads one
// pattern byte, kind 1 feeds one text byte, kind 2 ends the text and makes
// one result item (matched, error) on the result channel; kind 3 is dropped.
// Up to 32 pattern bytes are held; more, or a pattern byte after text, flags
// the error bit on the next result. Text length is unbounded.
// Throughput: one item per cycle while no end item waits for the result
// slot, set by the combinational prefix vector update (parallel compare against
// all stored bytes plus a log-depth star closure). An accepted item is held in
// the input register; an end item's result then goes to the result register.
// Stall: while a result waits, pattern and text items keep flowing; only a
// second end item waits in the input register until the result is taken.
// Reset: asynchronous, active low; clears the pattern count, prefix vector
// and flags and empties both registers. No clearing pass is needed.
`default_nettype none

module wildcard_pattern_matcher_core (
    input  logic                clk,
    input  logic                rst_n,
    wpm_item_if.sink            item,
    wpm_result_if.source        result
);
    import wpm_pkg::*;

    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_data_reg;

    logic    in_take;
    logic    in_adv;
    logic    end_load;
    step_t   step;
    result_t verdict;

    // input stage advance: only an end item needs a free result slot
    assign in_adv   = in_valid_reg
                      && (in_item_reg.kind != KIND_END || !out_valid_reg || result.ready);
    assign end_load = in_adv && (in_item_reg.kind == KIND_END);
    assign in_take  = item.valid && item.ready;

    assign item.ready = !in_valid_reg || in_adv;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            in_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_item_reg.kind   <= item.kind;
            in_item_reg.symbol <= item.symbol;
        end
    end

    // matcher
    assign step.valid = in_adv;
    assign step.item  = in_item_reg;

    wpm_nfa u_nfa (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .res   (verdict)
    );

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (end_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (end_load)
        begin
            out_data_reg <= verdict;
        end
    end

    assign result.valid   = out_valid_reg;
    assign result.matched = out_data_reg.matched;
    assign result.error   = out_data_reg.error;

    // checks
    a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        end_load |=> result.valid)
        else $error("end item produced no result");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(end_load))
        else $error("result appeared without an end item");

    a_stall_only_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        !item.ready |-> (in_valid_reg && in_item_reg.kind == KIND_END && result.valid))
        else $error("input stalled without a pending end item");

endmodule

`default_nettype wire

// ===== rtl/wpm_nfa.sv =====
// wpm_nfa: pattern store and prefix bit vector, updated once per step
// depends on wpm_pkg
`default_nettype none

module wpm_nfa (
    input  logic             clk,
    input  logic             rst_n,
    input  wpm_pkg::step_t   step,
    output wpm_pkg::result_t res
);
    import wpm_pkg::*;

    sym_t    store_reg [MAX_PATTERN];
    count_t  count_reg;
    count_t  count_next;
    prefix_t prefix_reg;
    prefix_t prefix_next;
    logic    text_seen_reg;
    logic    text_seen_next;
    logic    fault_reg;
    logic    fault_next;

    star_t   used_mask;
    star_t   star_mask;
    prefix_t closed;
    prefix_t text_vec;
    logic    store_wr;
    logic    end_step;

    // per-entry decode of the stored pattern
    always_comb
    begin
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            used_mask[i] = CNT_W'(i) < count_reg;
            star_mask[i] = used_mask[i] && (store_reg[i] == SYM_STAR);
        end
    end

    assign closed = star_close(prefix_reg, star_mask);

    // advance the prefix vector by one text symbol
    always_comb
    begin
        text_vec = '0;
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            if (used_mask[i] && closed[i])
            begin
                if (star_mask[i])
                begin
                    text_vec[i] = 1'b1;
                end
                else if (store_reg[i] == SYM_ANY || store_reg[i] == step.item.symbol)
                begin
                    text_vec[i + 1] = 1'b1;
                end
            end
        end
    end

    // verdict for an end item
    always_comb
    begin
        if (fault_reg)
        begin
            res.matched = 1'b0;
            res.error   = 1'b1;
        end
        else
        begin
            res.matched = closed[count_reg];
            res.error   = 1'b0;
        end
    end

    // next state per item kind
    always_comb
    begin
        count_next     = count_reg;
        prefix_next    = prefix_reg;
        text_seen_next = text_seen_reg;
        fault_next     = fault_reg;
        store_wr       = 1'b0;
        end_step       = 1'b0;
        if (step.valid)
        begin
            unique case (step.item.kind)
                KIND_PATTERN:
                begin
                    if (text_seen_reg || count_reg >= CNT_W'(MAX_PATTERN))
                    begin
                        fault_next = 1'b1;
                    end
                    else
                    begin
                        store_wr   = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
                KIND_TEXT:
                begin
                    prefix_next    = text_vec;
                    text_seen_next = 1'b1;
                end
                KIND_END:
                begin
                    end_step       = 1'b1;
                    count_next     = '0;
                    prefix_next    = PREFIX_W'(1);
                    text_seen_next = 1'b0;
                    fault_next     = 1'b0;
                end
                default:
                begin
                    end_step = 1'b0;
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            prefix_reg    <= PREFIX_W'(1);
            text_seen_reg <= 1'b0;
            fault_reg     <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            prefix_reg    <= prefix_next;
            text_seen_reg <= text_seen_next;
            fault_reg     <= fault_next;
        end
    end

    // pattern store, written at the fill position
    always_ff @(posedge clk)
    begin
        if (store_wr)
        begin
            store_reg[count_reg[IDX_W-1:0]] <= step.item.symbol;
        end
    end

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_PATTERN))
        else $error("pattern count beyond store size");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        end_step |=> (count_reg == '0 && prefix_reg == PREFIX_W'(1) && !fault_reg))
        else $error("end item did not clear the matcher");

    a_fault_no_match: assert property (@(posedge clk) disable iff (!rst_n)
        fault_reg |-> (res.error && !res.matched))
        else $error("faulted pair reports a match");

    a_no_store_after_text: assert property (@(posedge clk) disable iff (!rst_n)
        (store_wr && text_seen_reg) |-> 1'b0)
        else $error("pattern stored after text");

endmodule

`default_nettype wire
